FILE: hdl/acmp_pkg.sv
// ----------------------------------------------------------------------------
// acmp_pkg
// Shared types, constants and AES helper functions for the counter mode PRG.
// ----------------------------------------------------------------------------
package acmp_pkg;

  localparam int MaxBlocksDefault = 64;
  localparam int NumRounds        = 10;
  localparam int CountW           = 7;
  localparam int CfgDataW         = 64;
  localparam int CfgIdxW          = 2;
  localparam int RoundW           = 4;

  localparam logic [CfgIdxW-1:0] REG_SALT_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SALT_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STREAM_ID = 2'd2;

  localparam logic [63:0] BitMask = 64'h0101010101010101;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_OUT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                clr_ctr;
    logic                latch_mode;
    logic                start;
    logic                step;
    logic                final_rnd;
    logic [RoundW-1:0]   rnd;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for rounds one to ten.
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one; byte i sits at bits 8i+7:8i.
  function automatic logic [127:0] next_key(input logic [127:0] k,
                                            input logic [RoundW-1:0] rnd);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t[7:0]   = SBOX[k[111:104]] ^ rcon(rnd);
    t[15:8]  = SBOX[k[119:112]];
    t[23:16] = SBOX[k[127:120]];
    t[31:24] = SBOX[k[103:96]];
    w0 = k[31:0] ^ t;
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  // SubBytes, ShiftRows and, unless final, MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        r[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        r[32*c +: 32] = {a3 ^ al ^ xt(a3 ^ a0), a2 ^ al ^ xt(a2 ^ a3),
                         a1 ^ al ^ xt(a1 ^ a2), a0 ^ al ^ xt(a0 ^ a1)};
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/acmp_if.sv
// ----------------------------------------------------------------------------
// acmp_req_if / acmp_blk_if
// Valid/ready channels for requests and generated blocks.
// ----------------------------------------------------------------------------
interface acmp_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] block_count;
  logic       bit_mode;
  logic       restart;
  modport source (output valid, block_count, bit_mode, restart, input ready);
  modport sink   (input valid, block_count, bit_mode, restart, output ready);
endinterface

interface acmp_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic        last;
  modport source (output valid, block_low, block_high, last, input ready);
  modport sink   (input valid, block_low, block_high, last, output ready);
endinterface

FILE: hdl/aes_counter_mode_prg.sv
// ----------------------------------------------------------------------------
// aes_counter_mode_prg
// AES-128 counter mode pseudo-random generator, top level.
// ----------------------------------------------------------------------------
// Each request yields block_count blocks (saturated to MaxBlocks; zero gives
// none). Each block is made in steps: load counter and key, then the AES
// rounds with the round key expanded alongside, then hand the block over,
// which waits for the receiver; the next request is taken in the cycle after
// the last block is accepted. Writing any key register clears the block
// counter, and needs the block to be idle.
module aes_counter_mode_prg #(
  parameter int MaxBlocks = acmp_pkg::MaxBlocksDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [acmp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [acmp_pkg::CfgDataW-1:0] cfg_data,
  acmp_req_if.sink                      req,
  acmp_blk_if.source                    blk
);
  import acmp_pkg::*;

  dp_cmd_t cmd;

  acmp_ctrl #(.MaxBlocks(MaxBlocks)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_count   (req.block_count),
    .in_restart (req.restart),
    .out_valid  (blk.valid),
    .out_ready  (blk.ready),
    .out_last   (blk.last),
    .cmd        (cmd)
  );

  acmp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_bit_mode (req.bit_mode),
    .cmd         (cmd),
    .block_low   (blk.block_low),
    .block_high  (blk.block_high)
  );

  // A request is never taken while a block is offered.
  a_excl: assert property (@(posedge clk) disable iff (rst) blk.valid |-> !req.ready)
    else $error("request accepted while a block is pending");

  // A request for no blocks leaves the block ready for the next one.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.block_count == 7'd0) |=> req.ready)
    else $error("empty request did not return to idle");

  // The datapath never loads and steps at once.
  a_cmd: assert property (@(posedge clk) disable iff (rst) !(cmd.start && cmd.step))
    else $error("conflicting datapath commands");

endmodule

FILE: hdl/acmp_ctrl.sv
// ----------------------------------------------------------------------------
// acmp_ctrl
// Request sequencer: counts blocks and AES rounds, drives the datapath.
// ----------------------------------------------------------------------------
module acmp_ctrl #(
  parameter int MaxBlocks = acmp_pkg::MaxBlocksDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [acmp_pkg::CountW-1:0] in_count,
  input  logic                     in_restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_last,
  output acmp_pkg::dp_cmd_t        cmd
);
  import acmp_pkg::*;

  localparam logic [CountW-1:0] MaxCnt = CountW'(MaxBlocks);
  localparam logic [RoundW-1:0] LastRnd = RoundW'(NumRounds);

  ctrl_state_t       state, state_next;
  logic [CountW-1:0] left;
  logic [RoundW-1:0] rnd;
  logic [CountW-1:0] n_sat;
  logic              acc;

  assign n_sat = (in_count > MaxCnt) ? MaxCnt : in_count;
  assign acc   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (acc && n_sat != '0) state_next = S_LOAD;
      S_LOAD:  state_next = S_ROUND;
      S_ROUND: if (rnd == LastRnd) state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = (left == CountW'(1)) ? S_IDLE : S_LOAD;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    out_last       = (left == CountW'(1));
    cmd            = '0;
    cmd.rnd        = rnd;
    cmd.final_rnd  = (rnd == LastRnd);
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_mode = acc;
        cmd.clr_ctr    = acc && in_restart;
      end
      S_LOAD:  cmd.start = 1'b1;
      S_ROUND: cmd.step  = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // State, block and round counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left  <= '0;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && acc) left <= n_sat;
      if (state == S_OUT && out_ready) left <= left - CountW'(1);
      if (state == S_LOAD) rnd <= RoundW'(1);
      if (state == S_ROUND) rnd <= rnd + RoundW'(1);
    end
  end

endmodule

FILE: hdl/acmp_dp.sv
// ----------------------------------------------------------------------------
// acmp_dp
// AES-128 datapath: key registers, block counter, state and round key.
// ----------------------------------------------------------------------------
module acmp_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [acmp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [acmp_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         in_bit_mode,
  input  acmp_pkg::dp_cmd_t            cmd,
  output logic [63:0]                  block_low,
  output logic [63:0]                  block_high
);
  import acmp_pkg::*;

  logic [63:0]  salt_low, salt_high, stream_id;
  logic [63:0]  counter;
  logic [127:0] st, rk, rk_next, key0;
  logic         bit_mode;
  logic [127:0] res;

  assign key0    = {salt_high, salt_low ^ stream_id};
  assign rk_next = next_key(rk, cmd.rnd);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      salt_low  <= '0;
      salt_high <= '0;
      stream_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SALT_LOW:  salt_low  <= cfg_data;
        REG_SALT_HIGH: salt_high <= cfg_data;
        REG_STREAM_ID: stream_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block counter: cleared by a key write or a restart, bumped per block.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if ((cfg_we && cfg_index <= REG_STREAM_ID) || cmd.clr_ctr) begin
      counter <= '0;
    end else if (cmd.start) begin
      counter <= counter + 64'd1;
    end
  end

  // Cipher state, running round key and latched bit mode.
  always_ff @(posedge clk) begin
    if (cmd.latch_mode) bit_mode <= in_bit_mode;
    if (cmd.start) begin
      st <= {64'd0, counter} ^ key0;
      rk <= key0;
    end else if (cmd.step) begin
      st <= aes_round(st, cmd.final_rnd) ^ rk_next;
      rk <= rk_next;
    end
  end

  assign res        = st;
  assign block_low  = bit_mode ? (res[63:0] & BitMask) : res[63:0];
  assign block_high = bit_mode ? (res[127:64] & BitMask) : res[127:64];

endmodule

FILE: test/acmp_scoreboard.sv
// ----------------------------------------------------------------------------
// acmp_scoreboard
// Predicts the AES-128 counter mode blocks of each accepted request and
// checks the generated blocks against them in order.
// ----------------------------------------------------------------------------
class acmp_scoreboard;

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        last;
  } prg_block_t;

  logic [63:0] salt_low;
  logic [63:0] salt_high;
  logic [63:0] stream_id;
  logic [63:0] counter;
  logic [127:0] round_key [11];
  prg_block_t   pending_blocks [$];
  int           error_count;

  function new();
    salt_low = '0;
    salt_high = '0;
    stream_id = '0;
    error_count = 0;
    expand_key();
  endfunction

  static function logic [7:0] sub_byte(logic [7:0] b);
    return acmp_pkg::SBOX[b];
  endfunction

  static function logic [7:0] double_byte(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the key is bits 8i+7:8i; word j covers bytes 4j..4j+3.
  function void expand_key();
    logic [7:0] rc;
    logic [31:0] t;
    logic [127:0] k;
    rc = 8'h01;
    k = {salt_high, salt_low ^ stream_id};
    round_key[0] = k;
    for (int r = 1; r <= 10; r++) begin
      t = {sub_byte(k[103:96]), sub_byte(k[127:120]), sub_byte(k[119:112]),
           sub_byte(k[111:104]) ^ rc};
      k[31:0]   = k[31:0] ^ t;
      k[63:32]  = k[63:32] ^ k[31:0];
      k[95:64]  = k[95:64] ^ k[63:32];
      k[127:96] = k[127:96] ^ k[95:64];
      round_key[r] = k;
      rc = double_byte(rc);
    end
    counter = '0;
  endfunction

  function logic [127:0] cipher(logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] st;
    st = pt ^ round_key[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = st[8*i +: 8];
      // Substitution with the row shift folded into the byte pick.
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4*c+i] = sub_byte(s[4*((c+i)%4)+i]);
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ double_byte(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ double_byte(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ double_byte(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ double_byte(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[8*i +: 8] = t[i];
      st = st ^ round_key[r];
    end
    return st;
  endfunction

  function void write_register(logic [1:0] index, logic [63:0] value);
    case (index)
      acmp_pkg::REG_SALT_LOW:  salt_low = value;
      acmp_pkg::REG_SALT_HIGH: salt_high = value;
      acmp_pkg::REG_STREAM_ID: stream_id = value;
      default: return;
    endcase
    expand_key();
  endfunction

  // Notes an accepted request and queues the blocks it must produce.
  function void note_request(logic [6:0] count, logic bit_mode, logic restart);
    int n;
    logic [127:0] ct;
    prg_block_t b;
    if (restart) counter = '0;
    n = (count > 64) ? 64 : count;
    for (int i = 0; i < n; i++) begin
      ct = cipher({64'h0, counter});
      counter = counter + 64'd1;
      if (bit_mode) ct = ct & {acmp_pkg::BitMask, acmp_pkg::BitMask};
      b.block_low = ct[63:0];
      b.block_high = ct[127:64];
      b.last = (i == n - 1);
      pending_blocks.push_back(b);
    end
  endfunction

  function void check_block(logic [63:0] lo, logic [63:0] hi, logic last);
    prg_block_t e;
    if (pending_blocks.size() == 0) begin
      $display("%0t: unexpected block low=%h high=%h last=%b", $time, lo, hi, last);
      error_count++;
      return;
    end
    e = pending_blocks.pop_front();
    if (e.block_low !== lo) begin
      $display("%0t: block_low expected %h actual %h", $time, e.block_low, lo);
      error_count++;
    end
    if (e.block_high !== hi) begin
      $display("%0t: block_high expected %h actual %h", $time, e.block_high, hi);
      error_count++;
    end
    if (e.last !== last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, last);
      error_count++;
    end
  endfunction

endclass

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests and key writes into the counter mode PRG and checks every
// generated block against a predicted AES-128 encryption of the counter, masked in bit mode.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [acmp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [acmp_pkg::CfgDataW-1:0] cfg_data = '0;
  int sender_idle = 0;
  int receiver_stall = 0;

  acmp_req_if req ();
  acmp_blk_if blk ();
  acmp_scoreboard prg_model = new();

  aes_counter_mode_prg DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .blk(blk.source)
  );

  always #1 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.block_count = '0;
    req.bit_mode = 1'b0;
    req.restart = 1'b0;
    blk.ready = 1'b0;
  end

  // Receiver side: random stalls and block checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (blk.valid && blk.ready)
        prg_model.check_block(blk.block_low, blk.block_high, blk.last);
      blk.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  // The valid line stays high after an accepted item so that a following
  // item can be offered back to back; it drops while the sender idles, for key writes and at the end.
  task automatic send_request(logic [6:0] count, logic bit_mode, logic restart);
    while ($urandom_range(99) < sender_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.block_count <= count;
    req.bit_mode <= bit_mode;
    req.restart <= restart;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    prg_model.note_request(count, bit_mode, restart);
  endtask

  // Key writes happen only with nothing outstanding and the block quiet.
  task automatic write_register(logic [1:0] index, logic [63:0] value);
    req.valid <= 1'b0;
    while (prg_model.pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    prg_model.write_register(index, value);
  endtask

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 7'(64 + $urandom_range(63));
    if (r < 6) return 7'd0;
    if (r < 10) return 7'(64 - $urandom_range(3));
    return 7'($urandom_range(1, 6));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset key, extremes of count, modes, restart, oversize, zero, key writes, unused index.
    send_request(7'd1, 1'b0, 1'b0);
    send_request(7'd64, 1'b0, 1'b0);
    send_request(7'd127, 1'b1, 1'b0);
    send_request(7'd0, 1'b0, 1'b1);
    send_request(7'd2, 1'b1, 1'b1);
    send_request(7'd0, 1'b1, 1'b0);
    send_request(7'd65, 1'b0, 1'b1);
    write_register(acmp_pkg::REG_SALT_LOW, '1);
    write_register(acmp_pkg::REG_SALT_HIGH, '1);
    write_register(acmp_pkg::REG_STREAM_ID, '1);
    send_request(7'd3, 1'b0, 1'b0);
    write_register(acmp_pkg::REG_STREAM_ID, 64'h0);
    send_request(7'd3, 1'b1, 1'b0);
    write_register(2'd3, 64'h1234);
    send_request(7'd2, 1'b0, 1'b0);

    // Random phases across idling mixes, each after a register write to a random index (a key or the unused one).
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 73; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 73; end
        default: begin sender_idle = 37; receiver_stall = 37; end
      endcase
      write_register(2'($urandom_range(3)), rand64());
      if (phase == 4) write_register(acmp_pkg::REG_SALT_HIGH, '0);
      for (int i = 0; i < 57; i++)
        send_request(pick_count(), 1'($urandom()), ($urandom_range(9) == 0));
    end

    req.valid <= 1'b0;
    while (prg_model.pending_blocks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (prg_model.error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: aes_counter_mode_prg.f
hdl/acmp_pkg.sv
hdl/acmp_if.sv
hdl/acmp_ctrl.sv
hdl/acmp_dp.sv
hdl/aes_counter_mode_prg.sv
test/acmp_scoreboard.sv
test/testbench.sv
